[sv/sobel_edge_magnitude_rgb_defines.svh]
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH

// implication checked in the next cycle, off while in reset
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the next cycle, also across reset
`define SEM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/sem_pkg.sv]
// shared types and constants of the sobel edge magnitude block
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int GRAD_W     = 11;
    localparam int SUM_W      = 21;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(1024);
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(768);
    localparam logic [SUM_W-1:0]   ROOT_SAT     = SUM_W'(65280);
    localparam logic [CH_W-1:0]    CH_MAX       = CH_W'(255);

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_PUSH,
        ST_EMIT,
        ST_LAST
    } t_state;

    typedef enum logic [1:0] {
        WIN_HOLD,
        WIN_PUSH,
        WIN_CLEAR
    } t_win_op;

    typedef enum logic {
        VIEW_CURRENT,
        VIEW_FLUSH
    } t_view;

    // root unit step codes
    localparam logic [3:0] EST_GRAD      = 4'd0;
    localparam logic [3:0] EST_SQUARE    = 4'd1;
    localparam logic [3:0] EST_ROOT0     = 4'd2;
    localparam logic [3:0] EST_ROOT_LAST = 4'd9;
    localparam logic [3:0] EST_FINAL     = 4'd10;

    // window indexed [column left..right][row top..bottom]
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;
    typedef logic [2:0][2:0][CH_W-1:0]  t_lane;

    typedef struct packed {
        logic             accept;
        logic             pix_zero;
        logic [COL_W-1:0] col;
        t_win_op          win_op;
        logic             up_en;
        logic             mid_en;
        logic             ram_we;
        logic             emit_start;
        t_view            emit_view;
        logic             emit_end;
    } t_cmd;

    typedef struct packed {
        logic emit_busy;
    } t_stat;

    function automatic logic signed [GRAD_W-1:0] f_grad_x(t_lane p);
        logic [9:0] lo;
        logic [9:0] hi;
        lo = {2'b0, p[0][0]} + {1'b0, p[0][1], 1'b0} + {2'b0, p[0][2]};
        hi = {2'b0, p[2][0]} + {1'b0, p[2][1], 1'b0} + {2'b0, p[2][2]};
        return $signed({1'b0, hi}) - $signed({1'b0, lo});
    endfunction

    function automatic logic signed [GRAD_W-1:0] f_grad_y(t_lane p);
        logic [9:0] lo;
        logic [9:0] hi;
        lo = {2'b0, p[0][0]} + {1'b0, p[1][0], 1'b0} + {2'b0, p[2][0]};
        hi = {2'b0, p[0][2]} + {1'b0, p[1][2], 1'b0} + {2'b0, p[2][2]};
        return $signed({1'b0, hi}) - $signed({1'b0, lo});
    endfunction

endpackage

[sv/sem_ram.sv]
// generic single write port ram with registered read
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sem_ctrl.sv]
// controller: position counters, frame registers and item sequencing
module sem_ctrl
    import sem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_kind,
    output logic                  o_in_ready,
    input  t_stat                 i_stat,
    output t_cmd                  o_cmd
);

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col;
    logic [CFG_H_W-1:0] r_row;
    logic [CFG_W_W-1:0] r_width;
    logic [CFG_H_W-1:0] r_height;
    logic [COL_W-1:0]   r_cur_col;
    logic               r_f_c0, r_f_r1, r_f_r2, r_f_emit, r_f_last;

    logic [CFG_W_W-1:0] w_eff;
    logic [CFG_W_W-1:0] w_m1;
    logic [CFG_H_W-1:0] h_eff;
    logic               drain, at_end, last, accept;

    always_comb begin
        if (r_width == '0) begin
            w_eff = CFG_W_W'(1);
        end else if (r_width > CFG_W_W'(MAX_WIDTH)) begin
            w_eff = CFG_W_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        w_m1   = w_eff - CFG_W_W'(1);
        h_eff  = (r_height == '0) ? CFG_H_W'(1) : r_height;
        drain  = r_row >= h_eff;
        at_end = CFG_W_W'(r_col) >= w_m1;
        last   = drain && at_end;
        accept = i_in_valid && (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_f_c0   <= 1'b0;
            r_f_r1   <= 1'b0;
            r_f_r2   <= 1'b0;
            r_f_emit <= 1'b0;
            r_f_last <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_WIDTH:  r_width  <= i_cfg_data[CFG_W_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[CFG_H_W-1:0];
                    default:    r_width  <= r_width;
                endcase
            end
            if (accept) begin
                r_f_c0   <= r_col == '0;
                r_f_r1   <= r_row >= CFG_H_W'(1);
                r_f_r2   <= r_row >= CFG_H_W'(2);
                r_f_emit <= (r_col != '0) && (r_row >= CFG_H_W'(1));
                r_f_last <= last;
                if (at_end) begin
                    r_col <= '0;
                    r_row <= last ? '0 : r_row + CFG_H_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur_col <= r_col;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.col        = r_cur_col;
        o_cmd.win_op     = WIN_HOLD;
        o_cmd.emit_view  = VIEW_CURRENT;
        case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.col      = r_col;
                o_cmd.accept   = i_in_valid;
                o_cmd.pix_zero = drain || i_in_kind;
                if (i_in_valid) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (!r_f_c0) begin
                    n_state = ST_PUSH;
                end else if (!r_f_r2) begin
                    o_cmd.win_op = WIN_CLEAR;
                    n_state      = ST_PUSH;
                end else if (!i_stat.emit_busy) begin
                    o_cmd.emit_start = 1'b1;
                    o_cmd.emit_view  = VIEW_FLUSH;
                    o_cmd.win_op     = WIN_CLEAR;
                    n_state          = ST_PUSH;
                end
            end
            ST_PUSH: begin
                o_cmd.win_op = WIN_PUSH;
                o_cmd.up_en  = r_f_r2;
                o_cmd.mid_en = r_f_r1;
                o_cmd.ram_we = 1'b1;
                if (r_f_emit) begin
                    n_state = ST_EMIT;
                end else if (r_f_last) begin
                    n_state = ST_LAST;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!i_stat.emit_busy) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = r_f_last ? ST_LAST : ST_IDLE;
                end
            end
            ST_LAST: begin
                if (!i_stat.emit_busy) begin
                    o_cmd.emit_start = 1'b1;
                    o_cmd.emit_view  = VIEW_FLUSH;
                    o_cmd.emit_end   = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[sv/sem_dp.sv]
// datapath: line stores, pixel window, gradient and root unit, output register
module sem_dp
    import sem_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [PIX_W-1:0] i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [PIX_W-1:0] o_out_data,
    output logic             o_out_last
);

    logic [PIX_W-1:0] r_pix;
    logic [PIX_W-1:0] rd_up, rd_mid;
    t_win             r_win;
    t_win             view;

    logic                     r_e_busy;
    logic [3:0]               r_e_step;
    t_win                     r_e_win;
    logic                     r_e_end;
    logic signed [GRAD_W-1:0] r_gx   [NUM_CH];
    logic signed [GRAD_W-1:0] r_gy   [NUM_CH];
    logic [SUM_W-1:0]         r_sum  [NUM_CH];
    logic [CH_W-1:0]          r_root [NUM_CH];

    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_data;
    logic                 r_out_last;

    t_lane                lane   [NUM_CH];
    logic signed [21:0]   sq_x   [NUM_CH];
    logic signed [21:0]   sq_y   [NUM_CH];
    logic [CH_W-1:0]      trial  [NUM_CH];
    logic [15:0]          tsq    [NUM_CH];
    logic [16:0]          rnd    [NUM_CH];
    logic [CH_W-1:0]      fin    [NUM_CH];
    logic [2:0]           k;
    logic                 out_free;
    logic                 fin_load;

    // pixel word keeps red in the low byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_cmd.pix_zero ? '0
                   : {i_in_data[7:0], i_in_data[15:8], i_in_data[23:16]};
        end
    end

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_upper (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (i_cmd.col),
        .i_wdata (rd_mid),
        .i_re    (i_cmd.accept),
        .i_raddr (i_cmd.col),
        .o_rdata (rd_up)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_middle (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (i_cmd.col),
        .i_wdata (r_pix),
        .i_re    (i_cmd.accept),
        .i_raddr (i_cmd.col),
        .o_rdata (rd_mid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            case (i_cmd.win_op)
                WIN_PUSH: begin
                    r_win[0]    <= r_win[1];
                    r_win[1]    <= r_win[2];
                    r_win[2][0] <= i_cmd.up_en ? rd_up : '0;
                    r_win[2][1] <= i_cmd.mid_en ? rd_mid : '0;
                    r_win[2][2] <= r_pix;
                end
                WIN_CLEAR: r_win <= '0;
                default:   r_win <= r_win;
            endcase
        end
    end

    always_comb begin
        if (i_cmd.emit_view == VIEW_FLUSH) begin
            view    = '0;
            view[0] = r_win[1];
            view[1] = r_win[2];
        end else begin
            view = r_win;
        end
    end

    assign k        = 3'(r_e_step - EST_ROOT0);
    assign out_free = !r_out_valid || i_out_ready;
    assign fin_load = r_e_busy && (r_e_step == EST_FINAL) && out_free;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    lane[ch][c][r] = r_e_win[c][r][PIX_W-1-CH_W*ch -: CH_W];
                end
            end
            sq_x[ch]  = r_gx[ch] * r_gx[ch];
            sq_y[ch]  = r_gy[ch] * r_gy[ch];
            trial[ch] = r_root[ch] | (CH_W'(128) >> k);
            tsq[ch]   = trial[ch] * trial[ch];
            rnd[ch]   = 17'(r_root[ch] * r_root[ch]) + 17'(r_root[ch]);
            if (r_sum[ch] > ROOT_SAT) begin
                fin[ch] = CH_MAX;
            end else if (r_sum[ch] > SUM_W'(rnd[ch])) begin
                fin[ch] = r_root[ch] + CH_W'(1);
            end else begin
                fin[ch] = r_root[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_busy    <= 1'b0;
            r_e_step    <= EST_GRAD;
            r_out_valid <= 1'b0;
        end else begin
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit_start) begin
                r_e_busy <= 1'b1;
                r_e_step <= EST_GRAD;
                r_e_win  <= view;
                r_e_end  <= i_cmd.emit_end;
            end else if (r_e_busy) begin
                case (r_e_step) inside
                    EST_GRAD: begin
                        for (int ch = 0; ch < NUM_CH; ch++) begin
                            r_gx[ch] <= f_grad_x(lane[ch]);
                            r_gy[ch] <= f_grad_y(lane[ch]);
                        end
                        r_e_step <= EST_SQUARE;
                    end
                    EST_SQUARE: begin
                        for (int ch = 0; ch < NUM_CH; ch++) begin
                            r_sum[ch]  <= sq_x[ch][SUM_W-1:0] + sq_y[ch][SUM_W-1:0];
                            r_root[ch] <= '0;
                        end
                        r_e_step <= EST_ROOT0;
                    end
                    [EST_ROOT0:EST_ROOT_LAST]: begin
                        for (int ch = 0; ch < NUM_CH; ch++) begin
                            if (SUM_W'(tsq[ch]) <= r_sum[ch]) begin
                                r_root[ch] <= trial[ch];
                            end
                        end
                        r_e_step <= r_e_step + 4'd1;
                    end
                    EST_FINAL: begin
                        if (fin_load) begin
                            r_out_data <= {fin[2], fin[1], fin[0]};
                            r_out_last <= r_e_end;
                            r_e_busy   <= 1'b0;
                        end
                    end
                    default: r_e_busy <= 1'b0;
                endcase
            end
        end
    end

    assign o_stat.emit_busy = r_e_busy;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;
    assign o_out_last       = r_out_last;

endmodule

[sv/sobel_edge_magnitude_rgb.sv]
// top level: 3x3 sobel edge magnitude per rgb channel over a pixel stream
// an input word is sequenced through wrap, push and, where needed, emit and last states
// and causes up to two results; each result passes the shared gradient, square,
// bitwise root and final steps; a new word can be taken while the unit is busy
// synchronous reset clears counters, window and output, sets 1024 by 768
// line stores are not cleared and are read only where rows were written
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // red, green, blue
    input  logic                  s_axis_tuser,   // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // edge_red, edge_green, edge_blue
    output logic                  m_axis_tlast    // frame_end
);

    t_cmd  cmd;
    t_stat stat;

    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sem_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

[sv/sem_chk.sv]
// port checker for the sobel edge magnitude block and its bind
`include "sobel_edge_magnitude_rgb_defines.svh"

module sem_chk
    import sem_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [PIX_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);

    `SEM_ASSERT_NEXT_ALWAYS(a_reset_no_out, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")
    `SEM_ASSERT_NEXT(a_busy_after_word, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accepted word")
    `SEM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")

endmodule

bind sobel_edge_magnitude_rgb sem_chk u_sem_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
